@@ rtl/npc_pkg.sv @@
// Shared types and constants for the nearest palette color block.
// No dependencies; imported by every module under rtl/.
package npc_pkg;

  localparam int CHANNEL_W       = 8;
  localparam int COLOUR_W        = 24;
  localparam int INDEX_W         = 8;
  localparam int DIST_W          = 18;
  localparam int SQUARE_W        = 2 * CHANNEL_W;
  localparam int GREEN_LSB       = 8;
  localparam int BLUE_LSB        = 16;
  localparam int DEFAULT_ENTRIES = 256;

  // Largest possible distance: three channels at full difference.
  localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(3 * 255 * 255);

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Travels with each palette entry through the scan pipeline.
  typedef struct packed {
    logic               vld;
    logic               last;
    logic [INDEX_W-1:0] idx;
  } npc_tag_t;

endpackage

@@ rtl/npc_palette_mem.sv @@
// Palette storage: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on npc_pkg.
module npc_palette_mem #(
  parameter int ENTRIES = npc_pkg::DEFAULT_ENTRIES,
  parameter int ADDR_W  = $clog2(ENTRIES)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [npc_pkg::COLOUR_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]            rd_addr,
  output logic [npc_pkg::COLOUR_W-1:0] rd_data
);
  import npc_pkg::*;

  logic [COLOUR_W-1:0] mem [ENTRIES];
  logic [ENTRIES-1:0]  written;
  logic [COLOUR_W-1:0] rd_raw;
  logic                rd_written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_raw <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      rd_written <= written[rd_addr];
    end
  end

  assign rd_data = rd_written ? rd_raw : '0;

endmodule

@@ rtl/npc_dist.sv @@
// Pipelined squared-distance unit, shared by every palette entry of a scan.
// Three stages: channel differences, squares, sum. Depends on npc_pkg.
module npc_dist (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [npc_pkg::COLOUR_W-1:0] target,
  input  logic [npc_pkg::COLOUR_W-1:0] entry,
  input  npc_pkg::npc_tag_t            tag_in,
  output logic [npc_pkg::DIST_W-1:0]   sq_sum,
  output npc_pkg::npc_tag_t            tag_out
);
  import npc_pkg::*;

  logic [CHANNEL_W-1:0] diff_r, diff_g, diff_b;
  logic [SQUARE_W-1:0]  sq_r, sq_g, sq_b;
  npc_tag_t             tag_diff, tag_sq;

  function automatic logic [CHANNEL_W-1:0] abs_diff(
    input logic [CHANNEL_W-1:0] a,
    input logic [CHANNEL_W-1:0] b
  );
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // payload
  always_ff @(posedge clk) begin
    diff_r <= abs_diff(target[CHANNEL_W-1:0], entry[CHANNEL_W-1:0]);
    diff_g <= abs_diff(target[GREEN_LSB +: CHANNEL_W], entry[GREEN_LSB +: CHANNEL_W]);
    diff_b <= abs_diff(target[BLUE_LSB +: CHANNEL_W], entry[BLUE_LSB +: CHANNEL_W]);
    sq_r   <= SQUARE_W'(diff_r) * SQUARE_W'(diff_r);
    sq_g   <= SQUARE_W'(diff_g) * SQUARE_W'(diff_g);
    sq_b   <= SQUARE_W'(diff_b) * SQUARE_W'(diff_b);
    sq_sum <= DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
  end

  // tags
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_diff <= '0;
      tag_sq   <= '0;
      tag_out  <= '0;
    end else begin
      tag_diff <= tag_in;
      tag_sq   <= tag_diff;
      tag_out  <= tag_sq;
    end
  end

endmodule

@@ rtl/nearest_palette_colour_top.sv @@
// Nearest palette color top: sequencer and running minimum over npc_palette_mem, npc_dist.
// Write beat: the next beat can follow at once; no result.
// Lookup beat: the result follows a scan of one read per cycle, the 3-stage distance
// pipe, the minimum update and the result load; input stalls meanwhile. A waiting
// result does not block the next beat. Synchronous active-high reset clears control
// state and the palette (reads as zero).
module nearest_palette_colour_top #(
  parameter int PALETTE_ENTRIES = npc_pkg::DEFAULT_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         command,
  input  logic [npc_pkg::INDEX_W-1:0]  entry_index,
  input  logic [npc_pkg::COLOUR_W-1:0] colour,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [npc_pkg::INDEX_W-1:0]  best_index,
  output logic [npc_pkg::DIST_W-1:0]   nearest_distance
);
  import npc_pkg::*;

  localparam int ADDR_W = $clog2(PALETTE_ENTRIES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_ENTRIES - 1);

  // IDLE takes beats, SCAN issues one entry per cycle, DRAIN waits for the
  // pipeline to empty, FINISH hands the winner to the result register.
  typedef enum logic [1:0] {IDLE, SCAN, DRAIN, FINISH} state_t;

  state_t              state;
  logic [ADDR_W-1:0]   addr;
  logic [COLOUR_W-1:0] target;
  npc_tag_t            tag_rd;
  npc_tag_t            tag_dist;
  logic [COLOUR_W-1:0] rd_data;
  logic [DIST_W-1:0]   entry_distance;
  logic [INDEX_W-1:0]  run_index;
  logic [DIST_W-1:0]   run_dist;
  logic                take_beat;
  logic                wr_en;
  logic                better;
  logic                out_free;

  assign in_stall  = (state != IDLE);
  assign take_beat = in_valid && !in_stall;
  // Writes past the configured palette size are dropped.
  assign wr_en     = take_beat && (command == CMD_WRITE) &&
                     ({1'b0, entry_index} < (INDEX_W + 1)'(PALETTE_ENTRIES));
  assign out_free  = !out_valid || !out_stall;

  npc_palette_mem #(
    .ENTRIES (PALETTE_ENTRIES),
    .ADDR_W  (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (entry_index[ADDR_W-1:0]),
    .wr_data (colour),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  npc_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .target  (target),
    .entry   (rd_data),
    .tag_in  (tag_rd),
    .sq_sum  (entry_distance),
    .tag_out (tag_dist)
  );

  // Strict less-than keeps the lowest index on a tie; index 0 seeds the minimum.
  assign better = (tag_dist.idx == '0) || (entry_distance < run_dist);

  // Tag follows the registered memory read.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_rd <= '0;
    end else begin
      tag_rd.vld  <= (state == SCAN);
      tag_rd.last <= (addr == LAST_ADDR);
      tag_rd.idx  <= INDEX_W'(addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      addr      <= '0;
      out_valid <= 1'b0;
    end else begin
      // Result register: loaded from FINISH once free, else emptied by a taken beat.
      if ((state == FINISH) && out_free) begin
        out_valid        <= 1'b1;
        best_index       <= run_index;
        nearest_distance <= run_dist;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          addr <= '0;
          if (take_beat && (command == CMD_LOOKUP)) begin
            target <= colour;
            state  <= SCAN;
          end
        end
        SCAN: begin
          addr <= addr + 1'b1;
          if (addr == LAST_ADDR) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          if (tag_dist.vld && tag_dist.last) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
      if (tag_dist.vld && better) begin
        run_index <= tag_dist.idx;
        run_dist  <= entry_distance;
      end
    end
  end

  // A delivered distance never exceeds three full-scale channel squares.
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (nearest_distance <= MAX_DIST))
    else $error("nearest_distance out of range");

  // Scan pipeline only carries entries while a lookup is under way.
  a_tag_in_scan: assert property (@(posedge clk) disable iff (rst)
    tag_dist.vld |-> (state == SCAN || state == DRAIN))
    else $error("distance result outside a scan");

  // A new result is only loaded from FINISH.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> ($past(state) == FINISH))
    else $error("result appeared without a finished scan");

endmodule

@@ verif/nearest_palette_colour_top_tb.sv @@
// Self-checking testbench for nearest_palette_colour_top: palette writes and lookups
// against a behavioral nearest-color scoreboard. Depends on npc_pkg and the RTL top.
module nearest_palette_colour_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import npc_pkg::*;

  localparam int ENTRIES        = DEFAULT_ENTRIES;
  localparam int RANDOM_BEATS   = 1500;
  localparam int LONG_IDLE      = 40;
  // A lookup holds the input side for a full scan plus the pipeline tail.
  localparam int SCAN_CYCLES    = ENTRIES + 5;
  // Longest quiet stretch of a correct run: one scan, a long sender gap and a
  // long receiver stall back to back. Taken several times over.
  localparam int WATCHDOG_LIMIT = 8 * (SCAN_CYCLES + 2 * LONG_IDLE);

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic [DIST_W-1:0]  distance;
  } palette_match_t;

  // Keeps a shadow palette, predicts the winner of each lookup and checks
  // the results in order.
  class palette_match_checker;
    logic [COLOUR_W-1:0] palette [DEFAULT_ENTRIES];
    palette_match_t      awaited_matches [$];
    int                  errors;

    function new();
      foreach (palette[i]) palette[i] = '0;
      errors = 0;
    endfunction

    // Sum of squared per-channel differences.
    function logic [DIST_W-1:0] colour_gap(logic [COLOUR_W-1:0] a, logic [COLOUR_W-1:0] b);
      int sum;
      int d;
      sum = 0;
      for (int ch = 0; ch < 3; ch++) begin
        d = int'(a[ch*CHANNEL_W +: CHANNEL_W]) - int'(b[ch*CHANNEL_W +: CHANNEL_W]);
        sum += d * d;
      end
      return DIST_W'(sum);
    endfunction

    // Scan from index 0 upward; strict less-than keeps the lowest index on a tie.
    function palette_match_t find_nearest(logic [COLOUR_W-1:0] target);
      palette_match_t best;
      logic [DIST_W-1:0] d;
      best.idx      = '0;
      best.distance = colour_gap(target, palette[0]);
      for (int i = 1; i < DEFAULT_ENTRIES; i++) begin
        d = colour_gap(target, palette[i]);
        if (d < best.distance) begin
          best.distance = d;
          best.idx      = INDEX_W'(i);
        end
      end
      return best;
    endfunction

    task report(string msg);
      $display("%0t ns: %s", $time, msg);
      errors++;
    endtask

    function void note_beat(logic cmd, logic [INDEX_W-1:0] idx, logic [COLOUR_W-1:0] col);
      if (cmd == CMD_WRITE) begin
        if (int'(idx) < DEFAULT_ENTRIES) palette[idx] = col;
      end else begin
        awaited_matches.push_back(find_nearest(col));
      end
    endfunction

    task check_result(logic [INDEX_W-1:0] idx, logic [DIST_W-1:0] distance);
      palette_match_t want;
      if (awaited_matches.size() == 0) begin
        report($sformatf("unexpected result index %0d distance %0d", idx, distance));
      end else begin
        want = awaited_matches.pop_front();
        if (idx !== want.idx)
          report($sformatf("best_index got %0d want %0d", idx, want.idx));
        if (distance !== want.distance)
          report($sformatf("nearest_distance got %0d want %0d", distance, want.distance));
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                command;
  logic [INDEX_W-1:0]  entry_index;
  logic [COLOUR_W-1:0] colour;
  logic                out_valid;
  logic                out_stall;
  logic [INDEX_W-1:0]  best_index;
  logic [DIST_W-1:0]   nearest_distance;

  // When set, neither side idles: back-to-back beats and no output stalls.
  logic                no_idle;
  int                  quiet_cycles;

  palette_match_checker sb;

  nearest_palette_colour_top #(
    .PALETTE_ENTRIES(ENTRIES)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .entry_index     (entry_index),
    .colour          (colour),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .best_index      (best_index),
    .nearest_distance(nearest_distance)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, LONG_IDLE);
  endfunction

  // Drive one beat and return at the edge where it is taken. valid is only
  // dropped when a gap follows, so back-to-back beats never see a low/high
  // pair of assignments in the same step.
  task automatic send_beat(logic cmd, logic [INDEX_W-1:0] idx, logic [COLOUR_W-1:0] col);
    int gap;
    gap = no_idle ? 0 : pick_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    entry_index <= idx;
    colour      <= col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Output back-pressure: alternating stall and free spans of random length,
  // free-running so stalls land on every phase of a scan.
  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (no_idle) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (1 + pick_idle()) @(posedge clk);
        out_stall <= 1'b0;
        repeat (1 + pick_idle()) @(posedge clk);
      end
    end
  end

  // Monitor: values sampled at the edge are the pre-edge ones. Results are
  // checked before a new beat is noted so a stray result can't match it.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(best_index, nearest_distance);
      if (in_valid && !in_stall) sb.note_beat(command, entry_index, colour);
    end
  end

  // Watchdog: counts edges with no beat taken on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int                  kind;
    int                  n;
    int                  ch;
    int                  span;
    int                  mid;
    int                  v;
    int                  first;
    int                  second;
    logic [COLOUR_W-1:0] centre;
    logic [COLOUR_W-1:0] low_col;
    logic [COLOUR_W-1:0] high_col;
    logic [COLOUR_W-1:0] probe;

    rst          = 1'b1;
    in_valid     = 1'b0;
    command      = CMD_WRITE;
    entry_index  = '0;
    colour       = '0;
    no_idle      = 1'b0;
    sb           = new();

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part.
    // Fresh palette is all zero: every entry ties, index 0 wins; the second
    // lookup hits the largest possible distance. entry_index is noise here.
    send_beat(CMD_LOOKUP, 8'hAB, 24'h000000);
    send_beat(CMD_LOOKUP, 8'hFF, 24'hFFFFFF);
    // Top entry, exact hit and a near miss.
    send_beat(CMD_WRITE, 8'hFF, 24'hFFFFFF);
    send_beat(CMD_LOOKUP, 8'h00, 24'hFFFFFF);
    send_beat(CMD_LOOKUP, 8'h55, 24'hFEFEFE);
    // Same color at 0 and 255: lowest index takes the tie.
    send_beat(CMD_WRITE, 8'h00, 24'hFFFFFF);
    send_beat(CMD_LOOKUP, 8'hFF, 24'hFFFFFF);
    send_beat(CMD_WRITE, 8'h00, 24'h000000);
    // Two entries equally far on red, either side of the probe.
    send_beat(CMD_WRITE, 8'd7, 24'h102030);
    send_beat(CMD_WRITE, 8'd3, 24'h10202A);
    send_beat(CMD_LOOKUP, 8'd7, 24'h10202D);
    // One entry per channel, each channel's full range.
    send_beat(CMD_WRITE, 8'd1, 24'hFF0000);
    send_beat(CMD_WRITE, 8'd2, 24'h0000FF);
    send_beat(CMD_WRITE, 8'd4, 24'h00FF00);
    send_beat(CMD_LOOKUP, 8'd0, 24'hFF0000);
    send_beat(CMD_LOOKUP, 8'd0, 24'h0000FF);
    send_beat(CMD_LOOKUP, 8'd0, 24'h00FF00);
    send_beat(CMD_WRITE, 8'd128, 24'h55AA55);
    send_beat(CMD_LOOKUP, 8'd128, 24'hAA55AA);
    send_beat(CMD_LOOKUP, 8'd3, 24'h55AA56);

    // Random part.
    n = 0;
    while (n < RANDOM_BEATS) begin
      // Occasionally flip into or out of a no-idle stretch.
      if ($urandom_range(0, 99) == 0) no_idle = ~no_idle;
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        send_beat(CMD_WRITE, INDEX_W'($urandom), COLOUR_W'($urandom));
        n++;
      end else if (kind < 75) begin
        // Probe close to a known entry so small distances come up.
        probe = sb.palette[$urandom_range(0, ENTRIES - 1)];
        for (int c = 0; c < 3; c++) begin
          v = int'(probe[c*CHANNEL_W +: CHANNEL_W]) + int'($urandom_range(0, 12)) - 6;
          probe[c*CHANNEL_W +: CHANNEL_W] = CHANNEL_W'((v < 0) ? 0 : (v > 255) ? 255 : v);
        end
        send_beat(CMD_LOOKUP, INDEX_W'($urandom), probe);
        n++;
      end else if (kind < 88) begin
        send_beat(CMD_LOOKUP, INDEX_W'($urandom), COLOUR_W'($urandom));
        n++;
      end else if (kind < 95) begin
        // Tie setup: two entries mirrored about the probe on one channel,
        // written in either order.
        ch     = $urandom_range(0, 2);
        span   = $urandom_range(1, 20);
        mid    = $urandom_range(span, 255 - span);
        centre = COLOUR_W'($urandom);
        centre[ch*CHANNEL_W +: CHANNEL_W] = CHANNEL_W'(mid);
        low_col  = centre;
        high_col = centre;
        low_col[ch*CHANNEL_W +: CHANNEL_W]  = CHANNEL_W'(mid - span);
        high_col[ch*CHANNEL_W +: CHANNEL_W] = CHANNEL_W'(mid + span);
        first  = $urandom_range(0, ENTRIES - 2);
        second = $urandom_range(first + 1, ENTRIES - 1);
        if ($urandom_range(0, 1)) begin
          send_beat(CMD_WRITE, INDEX_W'(first), low_col);
          send_beat(CMD_WRITE, INDEX_W'(second), high_col);
        end else begin
          send_beat(CMD_WRITE, INDEX_W'(second), low_col);
          send_beat(CMD_WRITE, INDEX_W'(first), high_col);
        end
        send_beat(CMD_LOOKUP, INDEX_W'($urandom), centre);
        n += 3;
      end else begin
        // Extremes of every field.
        send_beat($urandom_range(0, 1) ? CMD_LOOKUP : CMD_WRITE,
                  $urandom_range(0, 1) ? 8'hFF : 8'h00,
                  $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000);
        n++;
      end
    end
    in_valid <= 1'b0;
    no_idle  = 1'b0;

    // Drain, then give a trailing write-only stretch time to settle.
    while (sb.awaited_matches.size() != 0) @(posedge clk);
    repeat (SCAN_CYCLES + 20) @(posedge clk);

    if (sb.errors == 0 && sb.awaited_matches.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ nearest_palette_colour_top.f @@
rtl/npc_pkg.sv
rtl/npc_palette_mem.sv
rtl/npc_dist.sv
rtl/nearest_palette_colour_top.sv
verif/nearest_palette_colour_top_tb.sv
